[sv/eqp_pkg.sv]
package eqp_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_PUSHBACK = 2'd1,
		OP_READ = 2'd2,
		OP_PEEK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_DELIVERED = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL = 3'd3,
		ST_NULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] code;
		logic [15:0] value;
		logic [7:0] ch;
	} entry_t;

endpackage

[sv/event_queue_with_pushback_top.sv]
// the result of an operation is strobed on done in the cycle after its transfer
// throughput: one operation per cycle; busy stays low, as head and count update at transfer
// the only read path is one registered port of the entry memory, issued at the head slot
// reset clears head index, entry count and the result strobe; entry memory is not cleared
// the receiver cannot stall: each result is on the ports for exactly one cycle
module event_queue_with_pushback_top
	import eqp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [15:0] event_code,
	input logic signed [15:0] event_value,
	input logic [7:0] event_char,
	output logic done,
	output logic [15:0] out_code,
	output logic signed [15:0] out_value,
	output logic [7:0] out_char,
	output logic [2:0] status
);

	// queue pointers
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	// result stage
	logic valid_s1;
	op_t op_s1;
	status_t status_s1;
	entry_t rdata_s1;

	logic accept;
	op_t op;
	logic is_full;
	logic is_empty;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] head_inc;
	logic we;
	logic [IDX_W-1:0] waddr;
	entry_t wdata;
	status_t status_d;
	logic [IDX_W-1:0] head_d;
	logic [CNT_W-1:0] count_d;

	// every operation touches only the head or tail slot, so nothing ever waits
	assign busy = 1'b0;
	assign accept = start && !busy;
	assign op = op_t'(operation);

	assign is_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	// tail slot = head + count, wrapped once around the ring
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
		? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
	assign head_dec = (head_q == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_q - IDX_W'(1);
	assign head_inc = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	assign wdata = '{code: event_code, value: event_value, ch: event_char};

	// decide the outcome and next pointers of the operation being transferred
	always_comb begin
		we = 1'b0;
		waddr = tail_idx;
		status_d = ST_STORED;
		head_d = head_q;
		count_d = count_q;
		unique case (op)
			OP_ENQUEUE: begin
				if (event_code == '0) begin
					// null event leaves the queue alone
					status_d = ST_NULL;
				end else if (is_full) begin
					status_d = ST_FULL;
				end else begin
					we = accept;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_PUSHBACK: begin
				// push-back stores even a zero code
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					we = accept;
					waddr = head_dec;
					head_d = head_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_READ: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_DELIVERED;
					head_d = head_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_PEEK: begin
				status_d = is_empty ? ST_EMPTY : ST_DELIVERED;
			end
			default: begin
				status_d = ST_EMPTY;
			end
		endcase
	end

	// entry memory: the head slot is read on every transfer, data lands in stage one
	eqp_store u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(head_q),
		.rdata(rdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				head_q <= head_d;
				count_q <= count_d;
			end
		end
	end

	// result payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			status_s1 <= status_d;
		end
	end

	// a read returns the whole head entry, a peek only its code; other outcomes are zero
	assign done = valid_s1;
	assign status = status_s1;
	assign out_code = (status_s1 == ST_DELIVERED) ? rdata_s1.code : '0;
	assign out_value = (status_s1 == ST_DELIVERED && op_s1 == OP_READ)
		? signed'(rdata_s1.value) : '0;
	assign out_char = (status_s1 == ST_DELIVERED && op_s1 == OP_READ)
		? rdata_s1.ch : '0;

	// each transfer gives exactly one result, in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("transfer without result");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without transfer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_s1 == ST_FULL |-> is_full)
		else $error("drop reported while queue not full");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_s1 == ST_EMPTY |-> is_empty)
		else $error("empty reported while queue holds entries");

endmodule

[sv/eqp_store.sv]
module eqp_store
	import eqp_pkg::*;
(
	input logic clk,
	input logic we,
	input logic [IDX_W-1:0] waddr,
	input entry_t wdata,
	input logic [IDX_W-1:0] raddr,
	output entry_t rdata
);

	entry_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
